@@ src/efla_pkg.sv @@
// ----------------------------------------------------------------------------
// efla_pkg
// Shared types and codes of the free list heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package efla_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_IGNORED   = 2'd1;
    localparam logic [1:0] STATUS_NO_MEMORY = 2'd2;

    typedef struct packed {
        logic        command;
        logic [15:0] request_bytes;
        logic [15:0] release_address;
    } efla_req_t;

    typedef struct packed {
        logic [15:0] payload_address;
        logic [15:0] granted_bytes;
        logic [1:0]  status;
    } efla_rsp_t;

endpackage

`default_nettype wire

@@ src/efla_ram.sv @@
// ----------------------------------------------------------------------------
// efla_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module efla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/efla_ctrl.sv @@
// ----------------------------------------------------------------------------
// efla_ctrl
// Sequencer that walks the free list and performs every read, modify and
// write of the heap store for allocate and free transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module efla_ctrl
    import efla_pkg::*;
#(
    parameter int HEAP_BYTES  = 65536,
    parameter int CHUNK_BYTES = 4096
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire efla_req_t                       req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output efla_rsp_t                            rsp,
    output logic                                 mem_we,
    output logic      [$clog2(HEAP_BYTES)-4:0]   mem_waddr,
    output logic      [$clog2(HEAP_BYTES)-1:0]   mem_wdata,
    output logic      [$clog2(HEAP_BYTES)-4:0]   mem_raddr,
    input  wire logic [$clog2(HEAP_BYTES)-1:0]   mem_rdata
);

    localparam int AW   = $clog2(HEAP_BYTES);
    localparam int CS   = ((CHUNK_BYTES + 15) / 16) * 16;
    localparam int WALK = HEAP_BYTES / 32 + 1;
    localparam int KW   = $clog2(WALK + 1);
    localparam int CW   = ((AW > 17) ? AW : 17) + 2;
    localparam logic [AW-1:0] CS_A = AW'(CS);
    localparam logic [AW-1:0] EIGHT = AW'(8);
    localparam logic [AW-1:0] SIXTEEN = AW'(16);

    typedef enum logic [5:0] {
        ST_INIT_A, ST_INIT_B, ST_IDLE, ST_RESP,
        ST_FR_RD, ST_FR_CHK, ST_FR_FT,
        ST_FF_START, ST_FF_HDR, ST_FF_CHK, ST_FF_NXT,
        ST_GROW, ST_GR1, ST_GR2,
        ST_MG0, ST_MG1, ST_MG2, ST_MG3, ST_MG4, ST_MG_TAG, ST_MG_FT,
        ST_UL0, ST_UL1, ST_UL2, ST_UL3,
        ST_PUSH, ST_PU_Z, ST_PU_H, ST_PU_L,
        ST_AL_UL, ST_AL_W0, ST_AL_S1, ST_AL_S2, ST_AL_S3, ST_AL_N1
    } state_t;

    typedef enum logic [1:0] {CTX_INIT, CTX_ALLOC, CTX_FREE} ctx_t;

    state_t          state_reg, state_next;
    ctx_t            ctx_reg, ctx_next;
    logic            ul_alloc_reg, ul_alloc_next;
    logic            pend_reg, pend_next;
    logic            pu_alloc_reg, pu_alloc_next;
    logic            pa_reg, pa_next;
    logic            na_reg, na_next;
    logic [16:0]     need_reg, need_next;
    logic [15:0]     addr_reg, addr_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW:0]     top_reg, top_next;
    logic [AW-1:0]   blk_reg, blk_next;
    logic [AW-1:0]   cur_reg, cur_next;
    logic [AW-1:0]   size_reg, size_next;
    logic [AW-1:0]   nb_reg, nb_next;
    logic [AW-1:0]   pb_reg, pb_next;
    logic [AW-1:0]   nsz_reg, nsz_next;
    logic [AW-1:0]   p_reg, p_next;
    logic [AW-1:0]   n_reg, n_next;
    logic [AW-1:0]   ulb_reg, ulb_next;
    logic [KW-1:0]   k_reg, k_next;
    efla_rsp_t       rsp_reg, rsp_next;

    logic [AW-1:0]   rd_byte, wr_byte;
    logic [AW-1:0]   rd_size;
    logic [AW-1:0]   rem;
    logic [CW-1:0]   fr_end;
    logic [CW-1:0]   gr_end;

    assign mem_raddr = rd_byte[AW-1:3];
    assign mem_waddr = wr_byte[AW-1:3];
    assign rd_size   = {mem_rdata[AW-1:4], 4'b0000};
    assign rem       = size_reg - AW'(need_reg);
    assign fr_end    = CW'(addr_reg) - CW'(8) + CW'(rd_size) + CW'(8);
    assign gr_end    = CW'(top_reg) + CW'(CS);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_RESP);
    assign rsp       = rsp_reg;

    always_comb begin
        state_next    = state_reg;
        ctx_next      = ctx_reg;
        ul_alloc_next = ul_alloc_reg;
        pend_next     = pend_reg;
        pu_alloc_next = pu_alloc_reg;
        pa_next       = pa_reg;
        na_next       = na_reg;
        need_next     = need_reg;
        addr_next     = addr_reg;
        head_next     = head_reg;
        top_next      = top_reg;
        blk_next      = blk_reg;
        cur_next      = cur_reg;
        size_next     = size_reg;
        nb_next       = nb_reg;
        pb_next       = pb_reg;
        nsz_next      = nsz_reg;
        p_next        = p_reg;
        n_next        = n_reg;
        ulb_next      = ulb_reg;
        k_next        = k_reg;
        rsp_next      = rsp_reg;
        rd_byte       = '0;
        wr_byte       = '0;
        mem_we        = 1'b0;
        mem_wdata     = '0;

        unique case (state_reg)
            ST_INIT_A: begin
                mem_we     = 1'b1;
                wr_byte    = '0;
                mem_wdata  = AW'(1);
                state_next = ST_INIT_B;
            end
            ST_INIT_B: begin
                mem_we     = 1'b1;
                wr_byte    = EIGHT;
                mem_wdata  = AW'(1);
                top_next   = (AW+1)'(16);
                head_next  = '0;
                ctx_next   = CTX_INIT;
                state_next = ST_GROW;
            end
            ST_IDLE: begin
                if (req_valid) begin
                    rsp_next  = '{payload_address: 16'd0, granted_bytes: 16'd0,
                                  status: STATUS_DONE};
                    addr_next = req.release_address;
                    need_next = (req.request_bytes <= 16'd16) ? 17'd32 :
                                ((17'(req.request_bytes) + 17'd31) & ~17'h0000F);
                    if (req.command == CMD_ALLOC) begin
                        if (req.request_bytes == 16'd0) begin
                            rsp_next.status = STATUS_IGNORED;
                            state_next      = ST_RESP;
                        end else begin
                            ctx_next   = CTX_ALLOC;
                            state_next = ST_FF_START;
                        end
                    end else begin
                        if (req.release_address == 16'd0 ||
                            req.release_address[3:0] != 4'd0) begin
                            rsp_next.status = STATUS_IGNORED;
                            state_next      = ST_RESP;
                        end else begin
                            blk_next   = AW'(req.release_address) - EIGHT;
                            state_next = ST_FR_RD;
                        end
                    end
                end
            end
            ST_RESP: begin
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FR_RD: begin
                rd_byte    = blk_reg;
                state_next = ST_FR_CHK;
            end
            ST_FR_CHK: begin
                if (!mem_rdata[0] || rd_size < AW'(32) || fr_end > CW'(top_reg)) begin
                    rsp_next.status = STATUS_IGNORED;
                    state_next      = ST_RESP;
                end else begin
                    size_next  = rd_size;
                    mem_we     = 1'b1;
                    wr_byte    = blk_reg;
                    mem_wdata  = rd_size;
                    state_next = ST_FR_FT;
                end
            end
            ST_FR_FT: begin
                mem_we     = 1'b1;
                wr_byte    = blk_reg + size_reg - EIGHT;
                mem_wdata  = size_reg;
                ctx_next   = CTX_FREE;
                state_next = ST_MG0;
            end
            ST_FF_START: begin
                cur_next   = head_reg;
                k_next     = '0;
                state_next = ST_FF_HDR;
            end
            ST_FF_HDR: begin
                if (k_reg == KW'(WALK) || cur_reg == '0) begin
                    state_next = ST_GROW;
                end else begin
                    rd_byte    = cur_reg;
                    k_next     = k_reg + KW'(1);
                    state_next = ST_FF_CHK;
                end
            end
            ST_FF_CHK: begin
                if (CW'(need_reg) <= CW'(rd_size)) begin
                    blk_next   = cur_reg;
                    size_next  = rd_size;
                    state_next = ST_AL_UL;
                end else begin
                    rd_byte    = cur_reg + SIXTEEN;
                    state_next = ST_FF_NXT;
                end
            end
            ST_FF_NXT: begin
                cur_next   = mem_rdata;
                state_next = ST_FF_HDR;
            end
            ST_GROW: begin
                if (gr_end > CW'(HEAP_BYTES)) begin
                    unique case (ctx_reg)
                        CTX_ALLOC: begin
                            rsp_next.status = STATUS_NO_MEMORY;
                            state_next      = ST_RESP;
                        end
                        CTX_INIT: state_next = ST_IDLE;
                        CTX_FREE: state_next = ST_IDLE;
                    endcase
                end else begin
                    blk_next   = AW'(top_reg) - EIGHT;
                    mem_we     = 1'b1;
                    wr_byte    = AW'(top_reg) - EIGHT;
                    mem_wdata  = CS_A;
                    state_next = ST_GR1;
                end
            end
            ST_GR1: begin
                mem_we     = 1'b1;
                wr_byte    = blk_reg + CS_A - EIGHT;
                mem_wdata  = CS_A;
                state_next = ST_GR2;
            end
            ST_GR2: begin
                mem_we     = 1'b1;
                wr_byte    = blk_reg + CS_A;
                mem_wdata  = AW'(1);
                top_next   = top_reg + (AW+1)'(CS);
                state_next = ST_MG0;
            end
            ST_MG0: begin
                rd_byte    = blk_reg - EIGHT;
                state_next = ST_MG1;
            end
            ST_MG1: begin
                pa_next    = mem_rdata[0];
                pb_next    = blk_reg - rd_size;
                rd_byte    = blk_reg;
                state_next = ST_MG2;
            end
            ST_MG2: begin
                size_next  = rd_size;
                nb_next    = blk_reg + rd_size;
                rd_byte    = blk_reg + rd_size;
                state_next = ST_MG3;
            end
            ST_MG3: begin
                na_next    = mem_rdata[0];
                nsz_next   = rd_size;
                rd_byte    = pb_reg;
                state_next = ST_MG4;
            end
            ST_MG4: begin
                ul_alloc_next = 1'b0;
                priority if (!pa_reg && !na_reg) begin
                    size_next  = size_reg + nsz_reg + rd_size;
                    blk_next   = pb_reg;
                    ulb_next   = pb_reg;
                    pend_next  = 1'b1;
                    state_next = ST_UL0;
                end else if (!pa_reg) begin
                    size_next  = size_reg + rd_size;
                    blk_next   = pb_reg;
                    ulb_next   = pb_reg;
                    pend_next  = 1'b0;
                    state_next = ST_UL0;
                end else if (!na_reg) begin
                    size_next  = size_reg + nsz_reg;
                    ulb_next   = nb_reg;
                    pend_next  = 1'b0;
                    state_next = ST_UL0;
                end else begin
                    state_next = ST_MG_TAG;
                end
            end
            ST_MG_TAG: begin
                mem_we     = 1'b1;
                wr_byte    = blk_reg;
                mem_wdata  = size_reg;
                state_next = ST_MG_FT;
            end
            ST_MG_FT: begin
                mem_we        = 1'b1;
                wr_byte       = blk_reg + size_reg - EIGHT;
                mem_wdata     = size_reg;
                pu_alloc_next = 1'b0;
                state_next    = ST_PUSH;
            end
            ST_UL0: begin
                rd_byte    = ulb_reg + EIGHT;
                state_next = ST_UL1;
            end
            ST_UL1: begin
                p_next     = mem_rdata;
                rd_byte    = ulb_reg + SIXTEEN;
                state_next = ST_UL2;
            end
            ST_UL2: begin
                n_next     = mem_rdata;
                state_next = ST_UL3;
                priority if (head_reg == '0) begin
                    state_next = ST_UL3;
                end else if (p_reg == '0 && mem_rdata == '0) begin
                    head_next = '0;
                end else if (p_reg == '0) begin
                    head_next = mem_rdata;
                    mem_we    = 1'b1;
                    wr_byte   = mem_rdata + EIGHT;
                    mem_wdata = '0;
                end else if (mem_rdata == '0) begin
                    mem_we    = 1'b1;
                    wr_byte   = p_reg + SIXTEEN;
                    mem_wdata = '0;
                end else begin
                    mem_we    = 1'b1;
                    wr_byte   = p_reg + SIXTEEN;
                    mem_wdata = mem_rdata;
                end
                // Only the case with both neighbours linked needs a second write.
                if (head_reg == '0 || p_reg == '0 || mem_rdata == '0) begin
                    if (ul_alloc_reg) begin
                        state_next = ST_AL_W0;
                    end else if (pend_reg) begin
                        ulb_next   = nb_reg;
                        pend_next  = 1'b0;
                        state_next = ST_UL0;
                    end else begin
                        state_next = ST_MG_TAG;
                    end
                end
            end
            ST_UL3: begin
                mem_we    = 1'b1;
                wr_byte   = n_reg + EIGHT;
                mem_wdata = p_reg;
                if (ul_alloc_reg) begin
                    state_next = ST_AL_W0;
                end else if (pend_reg) begin
                    ulb_next   = nb_reg;
                    pend_next  = 1'b0;
                    state_next = ST_UL0;
                end else begin
                    state_next = ST_MG_TAG;
                end
            end
            ST_PUSH: begin
                mem_we = 1'b1;
                if (head_reg == '0) begin
                    wr_byte    = blk_reg + EIGHT;
                    mem_wdata  = '0;
                    state_next = ST_PU_Z;
                end else begin
                    wr_byte    = blk_reg + SIXTEEN;
                    mem_wdata  = head_reg;
                    state_next = ST_PU_H;
                end
            end
            ST_PU_Z, ST_PU_L: begin
                mem_we    = 1'b1;
                wr_byte   = (state_reg == ST_PU_Z) ? blk_reg + SIXTEEN : blk_reg + EIGHT;
                mem_wdata = '0;
                head_next = blk_reg;
                if (pu_alloc_reg) begin
                    state_next = ST_RESP;
                end else begin
                    unique case (ctx_reg)
                        CTX_INIT:  state_next = ST_IDLE;
                        CTX_ALLOC: state_next = ST_FF_START;
                        CTX_FREE:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_PU_H: begin
                mem_we     = 1'b1;
                wr_byte    = head_reg + EIGHT;
                mem_wdata  = blk_reg;
                state_next = ST_PU_L;
            end
            ST_AL_UL: begin
                ulb_next      = blk_reg;
                ul_alloc_next = 1'b1;
                pend_next     = 1'b0;
                state_next    = ST_UL0;
            end
            ST_AL_W0: begin
                mem_we                   = 1'b1;
                wr_byte                  = blk_reg;
                rsp_next.payload_address = 16'(blk_reg + EIGHT);
                if (rem >= AW'(32)) begin
                    mem_wdata              = AW'(need_reg) | AW'(1);
                    rsp_next.granted_bytes = 16'(need_reg);
                    state_next             = ST_AL_S1;
                end else begin
                    mem_wdata              = size_reg | AW'(1);
                    rsp_next.granted_bytes = 16'(size_reg);
                    state_next             = ST_AL_N1;
                end
            end
            ST_AL_S1: begin
                mem_we     = 1'b1;
                wr_byte    = blk_reg + AW'(need_reg) - EIGHT;
                mem_wdata  = AW'(need_reg) | AW'(1);
                state_next = ST_AL_S2;
            end
            ST_AL_S2: begin
                mem_we     = 1'b1;
                wr_byte    = blk_reg + AW'(need_reg);
                mem_wdata  = rem;
                state_next = ST_AL_S3;
            end
            ST_AL_S3: begin
                mem_we        = 1'b1;
                wr_byte       = blk_reg + size_reg - EIGHT;
                mem_wdata     = rem;
                blk_next      = blk_reg + AW'(need_reg);
                pu_alloc_next = 1'b1;
                state_next    = ST_PUSH;
            end
            ST_AL_N1: begin
                mem_we     = 1'b1;
                wr_byte    = blk_reg + size_reg - EIGHT;
                mem_wdata  = size_reg | AW'(1);
                state_next = ST_RESP;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT_A;
            ctx_reg      <= CTX_INIT;
            ul_alloc_reg <= 1'b0;
            pend_reg     <= 1'b0;
            pu_alloc_reg <= 1'b0;
            head_reg     <= '0;
            top_reg      <= '0;
            k_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            ctx_reg      <= ctx_next;
            ul_alloc_reg <= ul_alloc_next;
            pend_reg     <= pend_next;
            pu_alloc_reg <= pu_alloc_next;
            head_reg     <= head_next;
            top_reg      <= top_next;
            k_reg        <= k_next;
        end
        pa_reg   <= pa_next;
        na_reg   <= na_next;
        need_reg <= need_next;
        addr_reg <= addr_next;
        blk_reg  <= blk_next;
        cur_reg  <= cur_next;
        size_reg <= size_next;
        nb_reg   <= nb_next;
        pb_reg   <= pb_next;
        nsz_reg  <= nsz_next;
        p_reg    <= p_next;
        n_reg    <= n_next;
        ulb_reg  <= ulb_next;
        rsp_reg  <= rsp_next;
    end

endmodule

`default_nettype wire

@@ src/explicit_free_list_allocator_top.sv @@
// ----------------------------------------------------------------------------
// explicit_free_list_allocator_top
// Boundary tag heap allocator with a LIFO free list, first fit search and
// chunked heap growth, held in one word store.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit first)                    | tuser
//  s_      | request   | request_bytes, release_address           | command
//  m_      | result    | payload_address, granted_bytes, status   | -
//
// Each transaction's length depends on the sequencer and the single read
// port of the heap store: it grows with each free list block visited, with
// each heap growth and, for a free, with the merge of its neighbours.
// After reset the sequencer writes the initial tags and chunk before
// s_tready rises. A new request is taken while a result still waits on the
// m_ side; the sequencer only stalls when it has a second result.
// ----------------------------------------------------------------------------
`default_nettype none

module explicit_free_list_allocator_top
    import efla_pkg::*;
#(
    parameter int HEAP_BYTES  = 65536,
    parameter int CHUNK_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // request_bytes, release_address
    input  wire logic        s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata    // payload_address, granted_bytes, status
);

    localparam int AW = $clog2(HEAP_BYTES);

    efla_req_t     req;
    efla_rsp_t     rsp;
    logic          rsp_valid, rsp_ready;
    logic          mem_we;
    logic [AW-4:0] mem_waddr, mem_raddr;
    logic [AW-1:0] mem_wdata, mem_rdata;
    logic          m_valid_reg;
    efla_rsp_t     m_data_reg;

    assign req.command         = s_tuser;
    assign req.request_bytes   = s_tdata[15:0];
    assign req.release_address = s_tdata[31:16];

    efla_ctrl #(
        .HEAP_BYTES (HEAP_BYTES),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    efla_ram #(
        .WIDTH(AW),
        .DEPTH(HEAP_BYTES / 8)
    ) u_heap (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign rsp_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rsp_ready) begin
            m_valid_reg <= rsp_valid;
        end
        if (rsp_ready && rsp_valid) begin
            m_data_reg <= rsp;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg.status, m_data_reg.granted_bytes,
                       m_data_reg.payload_address};

endmodule

`default_nettype wire
